// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define KV_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define KV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/kvmc_pkg.sv =====
// types, constants and lookup tables of the kana voicing-mark composer
// no dependencies
package kvmc_pkg;

  localparam int MaxOut = 8;
  localparam int QueueDepthDefault = 4;

  localparam logic [20:0] MarkDaku    = 21'h3099;
  localparam logic [20:0] MarkHandaku = 21'h309A;

  // bytes produced by one input byte, sent in order
  typedef struct packed {
    logic [MaxOut-1:0][7:0] data;
    logic [3:0]             count;
    logic                   last;
  } kvmc_bundle_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } kvmc_q_status_t;

  // code point length from the lead byte alone
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) len = 3'd1;
    else if (b[7:5] == 3'b110) len = 3'd2;
    else if (b[7:4] == 4'b1110) len = 3'd3;
    else if (b[7:3] == 5'b11110) len = 3'd4;
    else len = 3'd1;
    return len;
  endfunction

  // base kana to dakuten form, zero when there is none
  function automatic logic [15:0] daku_lookup(input logic [20:0] v);
    logic [15:0] c;
    unique case (v)
      21'h304B: c = 16'h304C;
      21'h304D: c = 16'h304E;
      21'h304F: c = 16'h3050;
      21'h3051: c = 16'h3052;
      21'h3053: c = 16'h3054;
      21'h3055: c = 16'h3056;
      21'h3057: c = 16'h3058;
      21'h3059: c = 16'h305A;
      21'h305B: c = 16'h305C;
      21'h305D: c = 16'h305E;
      21'h305F: c = 16'h3060;
      21'h3061: c = 16'h3062;
      21'h3064: c = 16'h3065;
      21'h3066: c = 16'h3067;
      21'h3068: c = 16'h3069;
      21'h306F: c = 16'h3070;
      21'h3072: c = 16'h3073;
      21'h3075: c = 16'h3076;
      21'h3078: c = 16'h3079;
      21'h307B: c = 16'h307C;
      21'h3046: c = 16'h3094;
      21'h30AB: c = 16'h30AC;
      21'h30AD: c = 16'h30AE;
      21'h30AF: c = 16'h30B0;
      21'h30B1: c = 16'h30B2;
      21'h30B3: c = 16'h30B4;
      21'h30B5: c = 16'h30B6;
      21'h30B7: c = 16'h30B8;
      21'h30B9: c = 16'h30BA;
      21'h30BB: c = 16'h30BC;
      21'h30BD: c = 16'h30BE;
      21'h30BF: c = 16'h30C0;
      21'h30C1: c = 16'h30C2;
      21'h30C4: c = 16'h30C5;
      21'h30C6: c = 16'h30C7;
      21'h30C8: c = 16'h30C9;
      21'h30CF: c = 16'h30D0;
      21'h30D2: c = 16'h30D3;
      21'h30D5: c = 16'h30D6;
      21'h30D8: c = 16'h30D9;
      21'h30DB: c = 16'h30DC;
      21'h30A6: c = 16'h30F4;
      21'h30EF: c = 16'h30F7;
      21'h30F0: c = 16'h30F8;
      21'h30F1: c = 16'h30F9;
      21'h30F2: c = 16'h30FA;
      default:  c = 16'h0000;
    endcase
    return c;
  endfunction

  // base kana to handakuten form, zero when there is none
  function automatic logic [15:0] handaku_lookup(input logic [20:0] v);
    logic [15:0] c;
    unique case (v)
      21'h306F: c = 16'h3071;
      21'h3072: c = 16'h3074;
      21'h3075: c = 16'h3077;
      21'h3078: c = 16'h307A;
      21'h307B: c = 16'h307D;
      21'h30CF: c = 16'h30D1;
      21'h30D2: c = 16'h30D4;
      21'h30D5: c = 16'h30D7;
      21'h30D8: c = 16'h30DA;
      21'h30DB: c = 16'h30DD;
      default:  c = 16'h0000;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/kvmc_front.sv =====
// front part: gathers code points, composes kana with voicing marks,
// and forms the byte bundle for each input byte; uses kvmc_pkg
module kvmc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output logic                  push,
  output kvmc_pkg::kvmc_bundle_t bundle
);
  import kvmc_pkg::*;

  logic [3:0][7:0] held_bytes, held_bytes_next;
  logic [2:0]      held_count, held_count_next;
  logic [20:0]     held_value, held_value_next;
  logic [2:0][7:0] partial_bytes, partial_bytes_next;
  logic [1:0]      partial_count, partial_count_next;
  logic [2:0]      expected_length, expected_length_next;
  logic [2:0]      bytes_seen, bytes_seen_next;

  logic [2:0]      exp_len;
  logic            complete;
  logic [3:0][7:0] seq;
  logic [20:0]     cp;
  logic            is_mark;
  logic [15:0]     composed;
  logic            compose;
  logic [3:0][7:0] seg1, seg2;
  logic [3:0]      c1, c2;
  logic [3:0]      j;

  // length and completion of the code point being gathered
  always_comb begin
    exp_len  = (partial_count == 2'd0) ? lead_length(in_byte) : expected_length;
    complete = ({1'b0, partial_count} + 3'd1) >= exp_len;
  end

  // gathered bytes with the new byte in place
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (i < int'(partial_count)) seq[i] = partial_bytes[i];
      else if (i == int'(partial_count)) seq[i] = in_byte;
      else seq[i] = 8'h00;
    end
    seq[3] = (partial_count == 2'd3) ? in_byte : 8'h00;
  end

  // code point value by length
  always_comb begin
    unique case (exp_len)
      3'd2:    cp = {10'd0, seq[0][4:0], seq[1][5:0]};
      3'd3:    cp = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
      3'd4:    cp = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
      default: cp = {13'd0, seq[0]};
    endcase
  end

  // composition with the held kana
  always_comb begin
    is_mark  = (cp == MarkDaku) || (cp == MarkHandaku);
    composed = (cp == MarkHandaku) ? handaku_lookup(held_value) : daku_lookup(held_value);
    compose  = complete && (held_count != 3'd0) && is_mark && (composed != 16'h0000);
  end

  // next state of held and partial code points
  always_comb begin
    held_bytes_next      = held_bytes;
    held_count_next      = held_count;
    held_value_next      = held_value;
    partial_bytes_next   = partial_bytes;
    partial_count_next   = partial_count;
    expected_length_next = exp_len;
    bytes_seen_next      = (bytes_seen < 3'd6) ? bytes_seen + 3'd1 : bytes_seen;
    if (complete) begin
      partial_count_next   = 2'd0;
      expected_length_next = 3'd0;
      if (compose) begin
        held_bytes_next[0] = {4'hE, composed[15:12]};
        held_bytes_next[1] = {2'b10, composed[11:6]};
        held_bytes_next[2] = {2'b10, composed[5:0]};
        held_value_next    = {5'd0, composed};
      end else begin
        held_bytes_next = seq;
        held_count_next = exp_len;
        held_value_next = cp;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (i == int'(partial_count)) partial_bytes_next[i] = in_byte;
      end
      partial_count_next = partial_count + 2'd1;
    end
  end

  // two segments of output bytes for this input byte
  always_comb begin
    seg1 = held_bytes;
    if (complete) begin
      c1   = compose ? 4'd0 : {1'b0, held_count};
      seg2 = held_bytes_next;
      c2   = in_last ? {1'b0, held_count_next} : 4'd0;
    end else begin
      c1   = in_last ? {1'b0, held_count} : 4'd0;
      seg2 = {8'h00, partial_bytes_next};
      c2   = (in_last && bytes_seen_next < 3'd6) ? {2'b00, partial_count_next} : 4'd0;
    end
  end

  // pack the segments into one bundle
  always_comb begin
    j = 4'd0;
    for (int i = 0; i < MaxOut; i++) begin
      j = 4'(i) - c1;
      if (4'(i) < c1) bundle.data[i] = seg1[2'(i)];
      else if (j < c2) bundle.data[i] = seg2[j[1:0]];
      else bundle.data[i] = 8'h00;
    end
    bundle.count = c1 + c2;
    bundle.last  = in_last;
    push         = accept && (bundle.count != 4'd0);
  end

  // state registers, cleared at the end of each string
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count      <= 3'd0;
      partial_count   <= 2'd0;
      expected_length <= 3'd0;
      bytes_seen      <= 3'd0;
    end else if (accept) begin
      held_bytes    <= held_bytes_next;
      held_value    <= held_value_next;
      partial_bytes <= partial_bytes_next;
      if (in_last) begin
        held_count      <= 3'd0;
        partial_count   <= 2'd0;
        expected_length <= 3'd0;
        bytes_seen      <= 3'd0;
      end else begin
        held_count      <= held_count_next;
        partial_count   <= partial_count_next;
        expected_length <= expected_length_next;
        bytes_seen      <= bytes_seen_next;
      end
    end
  end

endmodule

// ===== rtl/kvmc_queue.sv =====
// bundle queue between the front and back parts
// uses kvmc_pkg
module kvmc_queue #(
  parameter int Depth = kvmc_pkg::QueueDepthDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  kvmc_pkg::kvmc_bundle_t push_data,
  input  logic                   pop,
  output kvmc_pkg::kvmc_bundle_t head,
  output kvmc_pkg::kvmc_q_status_t status
);
  import kvmc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  kvmc_bundle_t    slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] fill;

  assign head             = slots[rd_ptr];
  assign status.not_empty = (fill != '0);
  assign status.full      = (fill == CntW'(Depth));

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

// ===== rtl/kvmc_back.sv =====
// back part: while out_tready is high, sends the bytes of each bundle one item per cycle
// uses kvmc_pkg
module kvmc_back (
  input  logic                     clk,
  input  logic                     rst,
  input  kvmc_pkg::kvmc_bundle_t   head,
  input  kvmc_pkg::kvmc_q_status_t status,
  output logic                     pop,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [7:0]               out_tdata,  // out_byte
  output logic                     out_tlast   // out_last
);
  import kvmc_pkg::*;

  kvmc_bundle_t cur;
  logic         cur_valid;
  logic [2:0]   idx;
  logic         at_end, take, done;

  // output item from the current bundle
  always_comb begin
    at_end     = ({1'b0, idx} == (cur.count - 4'd1));
    out_tvalid = cur_valid;
    out_tdata  = cur.data[idx];
    out_tlast  = cur.last && at_end;
    take       = cur_valid && out_tready;
    done       = take && at_end;
    pop        = (!cur_valid || done) && status.not_empty;
  end

  // bundle register and byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= 3'd0;
    end else if (done) begin
      cur_valid <= 1'b0;
    end else if (take) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

endmodule

// ===== rtl/kana_voicing_mark_composer.sv =====
// Input takes one byte per cycle whenever the bundle queue has room.
// Bytes of a code point leave once the next code point completes or the
// string ends, by way of the queue and then the back part's bundle register.
// Output sends one byte per cycle while ready, set by the back part's byte index.
// Synchronous reset empties the queue and clears the gathering counters.
module kana_voicing_mark_composer #(
  parameter int QueueDepth = kvmc_pkg::QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // in_byte
  input  logic       in_tlast,   // in_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic       out_tlast   // out_last
);
  import kvmc_pkg::*;

  kvmc_bundle_t   push_bundle, head;
  kvmc_q_status_t q_status;
  logic           accept, push, pop;

  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;

  kvmc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .push    (push),
    .bundle  (push_bundle)
  );

  kvmc_queue #(.Depth(QueueDepth)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_bundle),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  kvmc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .status     (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/kvmc_checker.sv =====
// port-level checks of the kana voicing-mark composer, bound to the top
// depends on assert_macros.svh
`include "assert_macros.svh"

module kvmc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  logic stall;

  // output item offered but not taken
  assign stall = out_tvalid && !out_tready;

  // a stalled output item stays offered
  `KV_ASSERT(a_out_hold, clk, rst, stall |=> out_tvalid, "output valid dropped")

  // a stalled output item keeps its payload
  `KV_ASSERT(a_out_stable, clk, rst, stall |=> $stable({out_tdata, out_tlast}), "payload changed")

  // an offered input item carries known bits
  `KV_ASSERT(a_in_known, clk, rst, in_tvalid |-> !$isunknown({in_tdata, in_tlast}), "x on input")

  // reset leaves nothing to send
  `KV_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !out_tvalid, "output valid after reset")

  // reset leaves the queue empty, so input is taken
  `KV_ASSERT_ALWAYS(a_rst_ready, clk, rst |=> in_tready, "input not ready after reset")

endmodule

bind kana_voicing_mark_composer kvmc_checker u_kvmc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== tb/kana_voicing_mark_composer_tb.sv =====
// testbench for kana_voicing_mark_composer: byte streams in, composed byte streams out
// predicts every output item from its own model of the composer and checks it in order
// depends on kvmc_pkg and the composer rtl
module kana_voicing_mark_composer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;
  localparam int RandomBytes = 340;
  localparam int MaxReports = 10;

  // base kana in the upper half, voiced form in the lower half
  localparam logic [31:0] DAKU_MAP [46] = '{
    32'h304B304C, 32'h304D304E, 32'h304F3050, 32'h30513052, 32'h30533054,
    32'h30553056, 32'h30573058, 32'h3059305A, 32'h305B305C, 32'h305D305E,
    32'h305F3060, 32'h30613062, 32'h30643065, 32'h30663067, 32'h30683069,
    32'h306F3070, 32'h30723073, 32'h30753076, 32'h30783079, 32'h307B307C,
    32'h30463094,
    32'h30AB30AC, 32'h30AD30AE, 32'h30AF30B0, 32'h30B130B2, 32'h30B330B4,
    32'h30B530B6, 32'h30B730B8, 32'h30B930BA, 32'h30BB30BC, 32'h30BD30BE,
    32'h30BF30C0, 32'h30C130C2, 32'h30C430C5, 32'h30C630C7, 32'h30C830C9,
    32'h30CF30D0, 32'h30D230D3, 32'h30D530D6, 32'h30D830D9, 32'h30DB30DC,
    32'h30A630F4, 32'h30EF30F7, 32'h30F030F8, 32'h30F130F9, 32'h30F230FA
  };
  localparam logic [31:0] HANDAKU_MAP [10] = '{
    32'h306F3071, 32'h30723074, 32'h30753077, 32'h3078307A, 32'h307B307D,
    32'h30CF30D1, 32'h30D230D4, 32'h30D530D7, 32'h30D830DA, 32'h30DB30DD
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // in_byte
  logic       in_tlast = 1'b0;    // in_last
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // out_byte
  logic       out_tlast;          // out_last

  // predicted composer state
  logic [3:0][7:0] hold_buf;
  logic [2:0]      hold_len;
  logic [20:0]     hold_cp;
  logic [2:0][7:0] part_buf;
  logic [1:0]      part_len;
  logic [2:0]      need_len;
  logic [2:0]      str_bytes;
  int              step_n;

  out_item_t  pending_out[$];
  logic [7:0] text_buf[$];
  int         fault_count = 0;
  int         cycle_count = 0;
  int         random_sent = 0;
  logic       calm = 1'b0;
  logic       rx_hold = 1'b0;
  event       rx_hold_ev;

  kana_voicing_mark_composer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic [2:0] seq_len(input logic [7:0] b);
    if (!b[7]) return 3'd1;
    if (b[7:5] == 3'b110) return 3'd2;
    if (b[7:4] == 4'b1110) return 3'd3;
    if (b[7:3] == 5'b11110) return 3'd4;
    return 3'd1;
  endfunction

  function automatic logic [15:0] voiced_form(input logic [20:0] base, input logic semi);
    logic [15:0] hit;
    hit = 16'h0000;
    if (semi) begin
      for (int i = 0; i < 10; i++)
        if (base == {5'b0, HANDAKU_MAP[i][31:16]}) hit = HANDAKU_MAP[i][15:0];
    end else begin
      for (int i = 0; i < 46; i++)
        if (base == {5'b0, DAKU_MAP[i][31:16]}) hit = DAKU_MAP[i][15:0];
    end
    return hit;
  endfunction

  // at most eight output items per input item
  function automatic void push_out(input logic [7:0] b);
    if (step_n < 8) begin
      pending_out.push_back('{data: b, last: 1'b0});
      step_n++;
    end
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < hold_len && i < 4; i++) push_out(hold_buf[i]);
    hold_len = 3'd0;
  endfunction

  function automatic void clear_state();
    hold_buf = '0;
    hold_len = 3'd0;
    hold_cp = 21'd0;
    part_buf = '0;
    part_len = 2'd0;
    need_len = 3'd0;
    str_bytes = 3'd0;
  endfunction

  // a completed code point either merges into the held kana or replaces it
  function automatic void absorb_codepoint(input logic [3:0][7:0] s, input logic [2:0] n);
    logic [20:0] cp;
    logic [15:0] voiced;
    case (n)
      3'd1:    cp = {13'b0, s[0]};
      3'd2:    cp = {10'b0, s[0][4:0], s[1][5:0]};
      3'd3:    cp = {5'b0, s[0][3:0], s[1][5:0], s[2][5:0]};
      default: cp = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
    endcase
    if (hold_len != 0 && (cp == kvmc_pkg::MarkDaku || cp == kvmc_pkg::MarkHandaku)) begin
      voiced = voiced_form(hold_cp, cp == kvmc_pkg::MarkHandaku);
      if (voiced != 16'h0000) begin
        hold_buf[0] = {4'hE, voiced[15:12]};
        hold_buf[1] = {2'b10, voiced[11:6]};
        hold_buf[2] = {2'b10, voiced[5:0]};
        hold_cp = {5'b0, voiced};
        return;
      end
    end
    flush_held();
    for (int i = 0; i < n && i < 4; i++) hold_buf[i] = s[i];
    hold_len = n;
    hold_cp = cp;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic last);
    logic [3:0][7:0] s;
    step_n = 0;
    if (str_bytes < 3'd6) str_bytes = str_bytes + 3'd1;
    if (part_len == 2'd0) need_len = seq_len(b);
    if ({1'b0, part_len} + 3'd1 >= need_len) begin
      s = '0;
      for (int i = 0; i < part_len; i++) s[i] = part_buf[i];
      s[part_len] = b;
      absorb_codepoint(s, need_len);
      part_len = 2'd0;
      need_len = 3'd0;
    end else begin
      part_buf[part_len] = b;
      part_len = part_len + 2'd1;
    end
    if (last) begin
      flush_held();
      // an unfinished tail survives only in short strings
      if (str_bytes < 3'd6)
        for (int i = 0; i < part_len; i++) push_out(part_buf[i]);
      if (step_n > 0) pending_out[pending_out.size() - 1].last = 1'b1;
      clear_state();
    end
  endfunction

  // ---------------------------------------------------------------- result side

  task automatic note_fault(input string what);
    fault_count++;
    if (fault_count <= MaxReports) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // ready pattern and in-order check of every accepted output item
  always @(posedge clk) begin
    out_item_t want;
    if (rst) out_tready <= 1'b0;
    else if (rx_hold) out_tready <= 1'b0;
    else if (calm) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= 11);
    if (!rst && out_tvalid && out_tready) begin
      if (pending_out.size() == 0) begin
        note_fault($sformatf("unexpected item byte=%02h last=%0b", out_tdata, out_tlast));
      end else begin
        want = pending_out.pop_front();
        if (out_tdata !== want.data || out_tlast !== want.last)
          note_fault($sformatf("byte exp=%02h got=%02h, last exp=%0b got=%0b",
                               want.data, out_tdata, want.last, out_tlast));
      end
    end
  end

  // long receiver hold-off, counted here
  initial forever begin
    @(rx_hold_ev);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- input side

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_byte(b, last);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) send_byte(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  // sender pauses until every predicted item has come out
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_out.size() != 0) @(posedge clk);
  endtask

  function automatic void put_kana3(input logic [15:0] cp);
    text_buf.push_back({4'hE, cp[15:12]});
    text_buf.push_back({2'b10, cp[11:6]});
    text_buf.push_back({2'b10, cp[5:0]});
  endfunction

  // overlong four-byte form of a bmp code point
  function automatic void put_overlong4(input logic [15:0] cp);
    text_buf.push_back(8'hF0);
    text_buf.push_back({4'b1000, cp[15:12]});
    text_buf.push_back({2'b10, cp[11:6]});
    text_buf.push_back({2'b10, cp[5:0]});
  endfunction

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(99) < 15) return 8'($urandom_range(255));
    return {2'b10, 6'($urandom_range(63))};
  endfunction

  function automatic logic [15:0] pick_base();
    if ($urandom_range(3) == 0) return HANDAKU_MAP[$urandom_range(9)][31:16];
    return DAKU_MAP[$urandom_range(45)][31:16];
  endfunction

  function automatic void put_random_cp();
    int r;
    r = $urandom_range(99);
    if (r < 30) put_kana3(pick_base());
    else if (r < 55) put_kana3($urandom_range(1) ? 16'h3099 : 16'h309A);
    else if (r < 65) text_buf.push_back(8'($urandom_range(127)));
    else if (r < 72) begin
      text_buf.push_back({4'hE, 4'($urandom_range(15))});
      text_buf.push_back(cont_byte());
      text_buf.push_back(cont_byte());
    end else if (r < 78) begin
      text_buf.push_back({3'b110, 5'($urandom_range(31))});
      text_buf.push_back(cont_byte());
    end else if (r < 83) begin
      text_buf.push_back({5'b11110, 3'($urandom_range(7))});
      repeat (3) text_buf.push_back(cont_byte());
    end else if (r < 88) put_overlong4(pick_base());
    else if (r < 94) begin
      // lead bytes that start nothing
      if ($urandom_range(1)) text_buf.push_back(8'($urandom_range(8'hBF, 8'h80)));
      else text_buf.push_back(8'($urandom_range(8'hFF, 8'hF8)));
    end else put_kana3(16'($urandom_range(16'h30FF, 16'h3040)));
  endfunction

  // mostly well-formed text, some broken tails, some pure noise
  function automatic void build_random_text();
    int n;
    if ($urandom_range(99) < 5) begin
      n = $urandom_range(8, 1);
      repeat (n) text_buf.push_back(8'($urandom_range(255)));
      return;
    end
    n = $urandom_range(6, 1);
    repeat (n) put_random_cp();
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(3))
        0: text_buf.push_back({3'b110, 5'($urandom_range(31))});
        1: text_buf.push_back({4'hE, 4'($urandom_range(15))});
        2: begin
          text_buf.push_back(8'hE3);
          text_buf.push_back(cont_byte());
        end
        default: begin
          text_buf.push_back({5'b11110, 3'($urandom_range(7))});
          repeat ($urandom_range(2)) text_buf.push_back(cont_byte());
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------- tests

  // ascii extremes and lead bytes that start no sequence
  task automatic test_plain_bytes();
    text_buf = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    send_text();
    wait_drain();
  endtask

  // composition, a repeated mark, a mark with nothing held, an overlong base
  task automatic test_voicing_marks();
    put_kana3(16'h304B);
    put_kana3(16'h3099);
    put_kana3(16'h3099);
    send_text();
    put_kana3(16'h309A);
    send_text();
    put_overlong4(16'h306F);
    put_kana3(16'h309A);
    send_text();
    wait_drain();
  endtask

  // unfinished sequence at the end of a short string is kept
  task automatic test_truncated_tail();
    text_buf = '{8'hE3, 8'h81};
    send_text();
    wait_drain();
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_output_stall();
    int sent;
    sent = 0;
    ->rx_hold_ev;
    while (sent < 60) begin
      build_random_text();
      sent += text_buf.size();
      send_text();
    end
    wait_drain();
  endtask

  // random text, the first stretch with no idling on either side
  task automatic test_random_text();
    calm <= 1'b1;
    while (random_sent < RandomBytes) begin
      if (random_sent >= 120) calm <= 1'b0;
      build_random_text();
      random_sent += text_buf.size();
      send_text();
      if ($urandom_range(99) < 10) wait_drain();
    end
    calm <= 1'b0;
    wait_drain();
  endtask

  initial begin
    clear_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_plain_bytes();
    test_voicing_marks();
    test_truncated_tail();
    test_output_stall();
    test_random_text();
    repeat (16) @(posedge clk);
    if (fault_count == 0 && pending_out.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
